// ----- hw/rtl/palc_pkg.sv -----
// Shared types and constants for the positional array list core.
// No dependencies; compiled before the interfaces and all modules.
package palc_pkg;

    // Default sizing of the list storage
    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the request and response fields
    localparam int OP_W     = 2;
    localparam int ELEM_W   = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_SEARCH   = 2'd2,
        OP_TRAVERSE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // Port strobes from the sequencer to the entry store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ----- hw/rtl/palc_if.sv -----
// Request and response channel interfaces of the positional array list core.
// Depends on palc_pkg for field widths.
interface palc_req_if;
    import palc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [ELEM_W-1:0] element;
    logic [POS_W-1:0]         position;

    modport source (output valid, output operation, output element, output position,
                    input ready);
    modport sink   (input valid, input operation, input element, input position,
                    output ready);
endinterface

interface palc_rsp_if;
    import palc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
    logic [COUNT_W-1:0]        count;
    logic                      last;

    modport source (output valid, output status, output value, output index,
                    output count, output last, input ready);
    modport sink   (input valid, input status, input value, input index,
                    input count, input last, output ready);
endinterface

// ----- hw/rtl/positional_array_list_core.sv -----
// Top level of the positional array list core: request decode, shift/scan
// sequencer and response register. Depends on palc_pkg, palc_if, palc_store.
// Usage:
//   i_req carries one request (operation, element, position); it is taken when
//   valid and ready are both high. Ready is high only while the sequencer is
//   idle; one request is worked on at a time.
//   o_rsp carries responses (status, value, index, count, last). Insert,
//   delete and search give one response; traverse gives one per stored entry
//   (or one empty status for an empty list), with last set on the final one.
// Sequencing: a rejected request goes straight to the emit state; an append
//   writes the new element with no shift; traverse reads, captures and emits
//   each entry in turn. One entry moved or compared per cycle: the store has
//   a single read and a single write port.
// Reset clears the count (list empty), the sequencer and the response valid;
// entry contents are not cleared and are only read after being written.
// A stalled receiver holds the response register; the sequencer waits in its
// emit state and no entry is lost. The next request is accepted as soon as the
// last response is in the output register, even if it is still waiting.
module positional_array_list_core #(
    parameter int DEPTH      = palc_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = palc_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    palc_req_if.sink   i_req,
    palc_rsp_if.source o_rsp
);
    import palc_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // entry address
    localparam int CW    = $clog2(DEPTH + 1);                // count 0..DEPTH
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INSERT = 7'b0000010,
        S_DELETE = 7'b0000100,
        S_SEARCH = 7'b0001000,
        S_TRAV   = 7'b0010000,
        S_TCAP   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_ptr, n_ptr;      // next store address to read (insert reads ptr-1)
    logic [CW-1:0]         r_pos, n_pos;      // request position, range checked
    logic [AW-1:0]         r_tag, n_tag;      // write address / index of read data
    logic                  r_first, n_first;  // pending read is the deleted entry
    logic                  r_rd_pend, n_rd_pend;
    logic [DATA_WIDTH-1:0] r_elem, n_elem;
    logic [VALUE_W-1:0]    r_val, n_val;
    logic [INDEX_W-1:0]    r_idx, n_idx;
    t_status               r_status, n_status;
    logic                  r_last, n_last;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [VALUE_W-1:0]    r_out_value;
    logic [INDEX_W-1:0]    r_out_index;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_last;

    t_mem_ctl              mem_ctl;
    logic [AW-1:0]         mem_raddr, mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata, rd_data;
    logic                  rd_match;
    logic [VALUE_W-1:0]    rd_value;
    logic                  in_fire, out_load;
    logic [CMP_W-1:0]      pos_ext, cnt_ext;

    palc_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_raddr   (mem_raddr),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_key     (r_elem),
        .o_rd_data (rd_data),
        .o_match   (rd_match)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign out_load    = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);
    assign pos_ext     = CMP_W'(i_req.position);
    assign cnt_ext     = CMP_W'(r_count);
    // stored word read back as a sign-extended response value
    assign rd_value    = VALUE_W'($signed(rd_data));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_tag     = r_tag;
        n_first   = r_first;
        n_rd_pend = r_rd_pend;
        n_elem    = r_elem;
        n_val     = r_val;
        n_idx     = r_idx;
        n_status  = r_status;
        n_last    = r_last;
        mem_ctl   = '0;
        mem_raddr = '0;
        mem_waddr = '0;
        mem_wdata = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_elem    = DATA_WIDTH'($signed(i_req.element));
                    n_val     = '0;
                    n_idx     = '0;
                    n_status  = ST_OK;
                    n_last    = 1'b1;
                    n_rd_pend = 1'b0;
                    n_first   = 1'b0;
                    n_pos     = CW'(i_req.position);
                    unique case (i_req.operation)
                        OP_INSERT: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_EMIT;
                            end else if (pos_ext > cnt_ext) begin
                                n_status = ST_BAD_POS;
                                n_state  = S_EMIT;
                            end else begin
                                n_ptr   = r_count;
                                n_state = S_INSERT;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else if (pos_ext >= cnt_ext) begin
                                n_status = ST_BAD_POS;
                                n_state  = S_EMIT;
                            end else begin
                                n_ptr   = CW'(i_req.position);
                                n_state = S_DELETE;
                            end
                        end
                        OP_SEARCH: begin
                            n_ptr   = '0;
                            n_state = S_SEARCH;
                        end
                        OP_TRAVERSE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_TRAV;
                            end
                        end
                    endcase
                end
            end

            // Shift up: read entry ptr-1, write it to ptr in the following cycle,
            // then drop the new element into the opened slot.
            S_INSERT: begin
                if (r_rd_pend) begin
                    mem_ctl.wr_en = 1'b1;
                    mem_waddr     = r_tag;
                    mem_wdata     = rd_data;
                end else if (r_ptr == r_pos) begin
                    mem_ctl.wr_en = 1'b1;
                    mem_waddr     = AW'(r_pos);
                    mem_wdata     = r_elem;
                    n_count       = CW'(r_count + CW'(1));
                    n_state       = S_EMIT;
                end
                if (r_ptr != r_pos) begin
                    mem_ctl.rd_en = 1'b1;
                    mem_raddr     = AW'(r_ptr - CW'(1));
                    n_tag         = AW'(r_ptr);
                    n_ptr         = CW'(r_ptr - CW'(1));
                    n_rd_pend     = 1'b1;
                end else begin
                    n_rd_pend     = 1'b0;
                end
            end

            // Shift down: first read returns the removed entry, the rest move
            // one slot lower.
            S_DELETE: begin
                if (r_rd_pend) begin
                    if (r_first) begin
                        n_val = rd_value;
                    end else begin
                        mem_ctl.wr_en = 1'b1;
                        mem_waddr     = r_tag;
                        mem_wdata     = rd_data;
                    end
                end
                if (r_ptr < r_count) begin
                    mem_ctl.rd_en = 1'b1;
                    mem_raddr     = AW'(r_ptr);
                    n_tag         = AW'(r_ptr - CW'(1));
                    n_first       = (r_ptr == r_pos);
                    n_ptr         = CW'(r_ptr + CW'(1));
                    n_rd_pend     = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        n_count = CW'(r_count - CW'(1));
                        n_state = S_EMIT;
                    end
                end
            end

            // Linear scan, lowest index first
            S_SEARCH: begin
                if (r_rd_pend && rd_match) begin
                    n_idx     = INDEX_W'(r_tag);
                    n_rd_pend = 1'b0;
                    n_state   = S_EMIT;
                end else if (r_ptr < r_count) begin
                    mem_ctl.rd_en = 1'b1;
                    mem_raddr     = AW'(r_ptr);
                    n_tag         = AW'(r_ptr);
                    n_ptr         = CW'(r_ptr + CW'(1));
                    n_rd_pend     = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    n_status  = ST_NOT_FOUND;
                    n_state   = S_EMIT;
                end
            end

            S_TRAV: begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = AW'(r_ptr);
                n_state       = S_TCAP;
            end

            S_TCAP: begin
                n_val    = rd_value;
                n_idx    = INDEX_W'(r_ptr);
                n_last   = (CW'(r_ptr + CW'(1)) == r_count);
                n_status = ST_OK;
                n_state  = S_EMIT;
            end

            S_EMIT: begin
                if (out_load) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = CW'(r_ptr + CW'(1));
                        n_state = S_TRAV;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_pend <= n_rd_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and response payload
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_pos    <= n_pos;
        r_tag    <= n_tag;
        r_first  <= n_first;
        r_elem   <= n_elem;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_last   <= n_last;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_value  <= r_val;
            r_out_index  <= r_idx;
            r_out_count  <= COUNT_W'(r_count);
            r_out_last   <= r_last;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.value  = r_out_value;
    assign o_rsp.index  = r_out_index;
    assign o_rsp.count  = r_out_count;
    assign o_rsp.last   = r_out_last;

`ifndef SYNTHESIS
    // Count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ((r_count == CW'($past(r_count) + CW'(1))) ||
             (r_count == CW'($past(r_count) - CW'(1)))))
        else $error("list count jumped by more than one");

    // Store is written only while shifting
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr_en |-> ((r_state == S_INSERT) || (r_state == S_DELETE)))
        else $error("entry store written outside insert or delete");

    // Loading the final response returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_last) |=> (r_state == S_IDLE))
        else $error("sequencer not idle after final response");

    // An accepted request always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("accepted request left sequencer idle");
`endif

endmodule

// ----- hw/rtl/palc_store.sv -----
// Entry store: single write port, single registered read port, and the
// equality compare used by search. Depends on palc_pkg.
module palc_store #(
    parameter int DEPTH      = palc_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = palc_pkg::DATA_WIDTH_DEF,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  palc_pkg::t_mem_ctl    i_ctl,
    input  logic [AW-1:0]         i_raddr,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [DATA_WIDTH-1:0] i_key,
    output logic [DATA_WIDTH-1:0] o_rd_data,
    output logic                  o_match
);
    import palc_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_raddr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_match   = (r_rd_data == i_key);

endmodule
